[hw/rtl/mtm_pkg.sv]
// shared constants, types and fp32 helper functions of the matrix tile multiplier
package mtm_pkg;

  localparam int ROWS    = 8;
  localparam int INNER   = 16;
  localparam int COLS    = 16;
  localparam int A_DEPTH = ROWS * INNER;
  localparam int B_DEPTH = INNER * COLS;
  localparam int A_AW    = $clog2(A_DEPTH);
  localparam int B_AW    = $clog2(B_DEPTH);
  localparam int K_W     = (INNER > 1) ? $clog2(INNER) : 1;
  localparam int C_W     = (COLS > 1) ? $clog2(COLS) : 1;

  localparam logic [1:0] OP_WR_A    = 2'd0;
  localparam logic [1:0] OP_WR_B    = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [2:0] ADDR_HALF_INPUTS = 3'd0;

  localparam logic [31:0] QNAN      = 32'h7FC0_0000;
  localparam logic [7:0]  EXP_MAX   = 8'hFF;
  localparam logic [7:0]  HALF_BIAS = 8'd112;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_LOAD, ST_MUL, ST_MNORM, ST_MRND,
    ST_ALIGN, ST_ADD, ST_ARND, ST_EMIT
  } state_t;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic start_row;
    logic load;
    logic mul;
    logic mnorm;
    logic mrnd;
    logic align;
    logic add;
    logic arnd;
    logic next_k;
    logic next_col;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic a_idx_ok;
    logic b_idx_ok;
    logic row_ok;
    logic last_k;
    logic last_col;
  } status_t;

  typedef struct packed {
    logic        s;
    logic [7:0]  e;
    logic [23:0] m;
    logic        zero;
    logic        inf;
    logic        nan;
  } fp_t;

  function automatic fp_t unpack(input logic [31:0] b);
    fp_t u;
    u.s    = b[31];
    u.e    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    u.m    = {b[30:23] != 8'd0, b[22:0]};
    u.zero = (b[30:23] == 8'd0) && (b[22:0] == 23'd0);
    u.inf  = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
    u.nan  = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
    return u;
  endfunction

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  fr;
    logic [3:0]  n;
    logic        found;
    logic [10:0] sh;
    ex = h[14:10];
    fr = h[9:0];
    n = 4'd0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found) begin
        if (fr[i]) found = 1'b1;
        else n = n + 4'd1;
      end
    end
    sh = {1'b0, fr} << (n + 4'd1);
    if (ex == 5'd0) begin
      if (fr == 10'd0) return {h[15], 31'd0};
      return {h[15], 8'(8'd113 - 8'(n) - 8'd1), sh[9:0], 13'd0};
    end
    if (ex == 5'h1F) return {h[15], EXP_MAX, fr, 13'd0};
    return {h[15], 8'(8'(ex) + HALF_BIAS), fr, 13'd0};
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  // sig has its leading bit at 26, three extra bits below the lsb
  function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                             input logic [26:0] sig);
    logic [26:0]        t;
    logic [10:0]        sh;
    logic               st;
    logic               sub;
    logic               inc;
    logic [24:0]        m;
    logic signed [10:0] e2;
    logic [22:0]        frac;
    sh = 11'd0;
    st = 1'b0;
    if (e > 0) begin
      t = sig;
      sub = 1'b0;
    end else begin
      sh = 11'(11'sd1 - e);
      sub = 1'b1;
      if (sh >= 11'd27) begin
        t = {26'd0, |sig};
      end else begin
        for (int i = 0; i < 27; i++) begin
          if (i < int'(sh)) st = st | sig[i];
        end
        t = (sig >> sh) | {26'd0, st};
      end
    end
    inc = t[2] & (t[1] | t[0] | t[3]);
    m = {1'b0, t[26:3]} + 25'(inc);
    if (sub) return {s, 7'd0, m[23], m[22:0]};
    e2 = m[24] ? (e + 11'sd1) : e;
    frac = m[24] ? m[23:1] : m[22:0];
    if (e2 >= 11'sd255) return {s, EXP_MAX, 23'd0};
    return {s, e2[7:0], frac};
  endfunction

endpackage

[hw/rtl/mtm_ram.sv]
// generic simple dual-port ram with registered read
module mtm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/mtm_ctrl.sv]
// sequencer for element writes and the row multiply-accumulate steps
module mtm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       op,
  input  mtm_pkg::status_t st,
  output mtm_pkg::cmd_t    cmd,
  output logic             busy
);
  import mtm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (op)
            OP_WR_A: cmd.wr_a = st.a_idx_ok;
            OP_WR_B: cmd.wr_b = st.b_idx_ok;
            OP_COMPUTE: begin
              if (st.row_ok) begin
                cmd.start_row = 1'b1;
                state_next = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: begin
        cmd.load = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_MNORM;
      end
      ST_MNORM: begin
        cmd.mnorm = 1'b1;
        state_next = ST_MRND;
      end
      ST_MRND: begin
        cmd.mrnd = 1'b1;
        state_next = ST_ALIGN;
      end
      ST_ALIGN: begin
        cmd.align = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        state_next = ST_ARND;
      end
      ST_ARND: begin
        cmd.arnd = 1'b1;
        if (st.last_k) begin
          state_next = ST_EMIT;
        end else begin
          cmd.next_k = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.next_col = 1'b1;
        state_next = st.last_col ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/mtm_dp.sv]
// stores, counters and the fp32 multiply and add datapath
module mtm_dp (
  input  logic             clk,
  input  logic             rst,
  input  mtm_pkg::cmd_t    cmd,
  output mtm_pkg::status_t st,
  input  logic             half_inputs,
  input  logic [7:0]       element_index,
  input  logic [31:0]      element_bits,
  input  logic [2:0]       out_row,
  output logic [31:0]      sum_bits,
  output logic [3:0]       out_column,
  output logic             last_of_row
);
  import mtm_pkg::*;

  logic [2:0]     row;
  logic [K_W-1:0] k;
  logic [C_W-1:0] col;
  logic [31:0]    a_rdata, b_rdata;
  logic [A_AW-1:0] a_raddr;
  logic [B_AW-1:0] b_raddr;

  logic [31:0] opa, opb;
  logic [47:0] prod;
  logic        ps, pnan, pinf, pzero;
  logic signed [10:0] pe;
  logic signed [10:0] me;
  logic [26:0] msig;
  logic [31:0] pbits;

  logic        al_s, al_sub, al_nan, al_inf;
  logic [7:0]  al_e;
  logic [26:0] al_a, al_b;
  logic signed [10:0] ad_e;
  logic [26:0] ad_sig;
  logic        ad_zero;
  logic [31:0] acc;

  fp_t ua, ub, ux, uy, ubig, usml;
  logic [31:0] big, sml;
  logic [5:0]  mlz;
  logic [47:0] mshift;
  logic [7:0]  d;
  logic [26:0] bsh;
  logic        bst;
  logic [27:0] r;
  logic [4:0]  alz;
  logic [26:0] ashift;

  assign st.a_idx_ok = int'(element_index) < A_DEPTH;
  assign st.b_idx_ok = int'(element_index) < B_DEPTH;
  assign st.row_ok   = int'(out_row) < ROWS;
  assign st.last_k   = k == K_W'(INNER - 1);
  assign st.last_col = col == C_W'(COLS - 1);

  assign a_raddr = A_AW'(int'(row) * INNER + int'(k));
  assign b_raddr = B_AW'(int'(k) * COLS + int'(col));

  mtm_ram #(.WIDTH(32), .DEPTH(A_DEPTH)) u_left (
    .clk(clk), .we(cmd.wr_a), .waddr(A_AW'(element_index)), .wdata(element_bits),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  mtm_ram #(.WIDTH(32), .DEPTH(B_DEPTH)) u_right (
    .clk(clk), .we(cmd.wr_b), .waddr(B_AW'(element_index)), .wdata(element_bits),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      col <= '0;
    end else if (cmd.start_row) begin
      k <= '0;
      col <= '0;
    end else if (cmd.next_k) begin
      k <= k + K_W'(1);
    end else if (cmd.next_col) begin
      k <= '0;
      col <= st.last_col ? '0 : col + C_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_row) row <= out_row;
  end

  always_comb begin
    ua = unpack(opa);
    ub = unpack(opb);
    mlz = lzc48(prod);
    mshift = prod << mlz;
    ux = unpack(acc);
    uy = unpack(pbits);
    if (pbits[30:0] > acc[30:0]) begin
      big = pbits;
      sml = acc;
    end else begin
      big = acc;
      sml = pbits;
    end
    ubig = unpack(big);
    usml = unpack(sml);
    d = ubig.e - usml.e;
    bst = 1'b0;
    if (d >= 8'd27) begin
      bsh = {26'd0, |usml.m};
    end else begin
      for (int i = 0; i < 27; i++) begin
        if (i < int'(d)) bst = bst | (i >= 3 ? usml.m[i-3] : 1'b0);
      end
      bsh = ({usml.m, 3'd0} >> d) | {26'd0, bst};
    end
    r = al_sub ? ({1'b0, al_a} - {1'b0, al_b}) : ({1'b0, al_a} + {1'b0, al_b});
    alz = lzc27(r[26:0]);
    ashift = r[26:0] << alz;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opa <= half_inputs ? widen_half(a_rdata[15:0]) : a_rdata;
      opb <= half_inputs ? widen_half(b_rdata[15:0]) : b_rdata;
    end
    if (cmd.mul) begin
      prod  <= ua.m * ub.m;
      ps    <= ua.s ^ ub.s;
      pe    <= 11'(11'(ua.e) + 11'(ub.e) - 11'd126);
      pnan  <= ua.nan | ub.nan | (ua.inf & ub.zero) | (ua.zero & ub.inf);
      pinf  <= ua.inf | ub.inf;
      pzero <= ua.zero | ub.zero;
    end
    if (cmd.mnorm) begin
      msig <= {mshift[47:22], |mshift[21:0]};
      me   <= pe - 11'(mlz);
    end
    if (cmd.mrnd) begin
      if (pnan) pbits <= QNAN;
      else if (pinf) pbits <= {ps, EXP_MAX, 23'd0};
      else if (pzero) pbits <= {ps, 31'd0};
      else pbits <= round_pack(ps, me, msig);
    end
    if (cmd.align) begin
      al_s   <= big[31];
      al_sub <= acc[31] ^ pbits[31];
      al_nan <= ux.nan | uy.nan | (ux.inf & uy.inf & (acc[31] != pbits[31]));
      al_inf <= ux.inf | uy.inf;
      al_e   <= ubig.e;
      al_a   <= {ubig.m, 3'd0};
      al_b   <= bsh;
    end
    if (cmd.add) begin
      ad_zero <= r == 28'd0;
      if (r[27]) begin
        ad_sig <= {r[27:2], r[1] | r[0]};
        ad_e   <= 11'(al_e) + 11'sd1;
      end else begin
        ad_sig <= ashift;
        ad_e   <= 11'(al_e) - 11'(alz);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_row || cmd.next_col) begin
      acc <= 32'd0;
    end else if (cmd.arnd) begin
      if (al_nan) acc <= QNAN;
      else if (al_inf) acc <= {al_s, EXP_MAX, 23'd0};
      else if (ad_zero) acc <= {al_sub ? 1'b0 : al_s, 31'd0};
      else acc <= round_pack(al_s, ad_e, ad_sig);
    end
  end

  assign sum_bits    = acc;
  assign out_column  = 4'(col);
  assign last_of_row = st.last_col;

endmodule

[hw/rtl/matrix_tile_multiply_fp.sv]
// top level of the fp32 matrix tile multiplier with register port
// Loads A (8x16) and B (16x16) elements one per cycle while busy is low, with op 0/1;
// writes never raise busy. A compute item (op 2) raises busy and yields the 16 fp32 sums of
// the chosen row, each shown for one cycle with valid high and last_of_row on column 15.
// Each multiply-add runs through one shared multiply and add datapath in the steps read,
// load, multiply, normalise, round, align, add and round; each column ends with an emit step.
// The receiver cannot stall; results must be taken in the cycle valid is high.
// half_inputs (address 0) selects fp16 elements and is read during compute.
module matrix_tile_multiply_fp (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [7:0]  element_index,
  input  logic [31:0] element_bits,
  input  logic [2:0]  out_row,
  output logic        valid,
  output logic [31:0] sum_bits,
  output logic [3:0]  out_column,
  output logic        last_of_row,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mtm_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    half_inputs;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_HALF_INPUTS[2]) ? {31'd0, half_inputs} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) half_inputs <= 1'b0;
    else if (psel && penable && pwrite && pready && paddr[2] == ADDR_HALF_INPUTS[2])
      half_inputs <= pwdata[0];
  end

  mtm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .op(op), .st(st), .cmd(cmd), .busy(busy)
  );

  mtm_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .half_inputs(half_inputs),
    .element_index(element_index), .element_bits(element_bits), .out_row(out_row),
    .sum_bits(sum_bits), .out_column(out_column), .last_of_row(last_of_row)
  );

  assign valid = cmd.emit;

endmodule

[hw/rtl/mtm_checker.sv]
// port-level checks of the matrix tile multiplier and their bind
module mtm_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  op,
  input logic [2:0]  out_row,
  input logic        valid,
  input logic [3:0]  out_column,
  input logic        last_of_row
);
  import mtm_pkg::*;

  a_valid_busy: assert property (@(posedge clk) disable iff (rst) valid |-> busy)
    else $error("result shown while idle");

  a_row_continues: assert property (@(posedge clk) disable iff (rst)
    valid && !last_of_row |=> busy)
    else $error("row ended before its last item");

  a_last_col: assert property (@(posedge clk) disable iff (rst)
    valid && last_of_row |-> out_column == 4'(COLS - 1))
    else $error("last item not on final column");

  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    start && !busy && op == OP_COMPUTE && int'(out_row) < ROWS |=> busy)
    else $error("compute item did not start");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (op == OP_WR_A || op == OP_WR_B) |=> !busy)
    else $error("write item raised busy");

endmodule

bind matrix_tile_multiply_fp mtm_checker u_mtm_checker (.*);

[sim/matrix_tile_multiply_fp_checker.sv]
// result checker of the matrix tile multiplier: store mirror, fp32 row prediction, compare
module matrix_tile_multiply_fp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  op,
  input  logic [7:0]  element_index,
  input  logic [31:0] element_bits,
  input  logic [2:0]  out_row,
  input  logic        valid,
  input  logic [31:0] sum_bits,
  input  logic [3:0]  out_column,
  input  logic        last_of_row,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  import mtm_pkg::*;

  typedef struct {
    logic [31:0] sum;
    logic [3:0]  col;
    logic        last;
  } row_sum_t;

  logic [31:0] a_mirror [A_DEPTH];
  logic [31:0] b_mirror [B_DEPTH];
  logic        half_mode;
  row_sum_t    sums_due [$];

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] s;
    logic [4:0]  ex;
    logic [10:0] fr;
    int          e;
    s = {h[15], 31'd0};
    ex = h[14:10];
    fr = {1'b0, h[9:0]};
    if (ex == 5'd0) begin
      if (fr == 11'd0) return s;
      e = 113;
      while (!fr[10]) begin
        fr = fr << 1;
        e--;
      end
      return s | (32'(e) << 23) | (32'(fr[9:0]) << 13);
    end
    if (ex == 5'h1F) return s | 32'h7F80_0000 | (32'(fr[9:0]) << 13);
    return s | (32'(ex + 8'd112) << 23) | (32'(fr[9:0]) << 13);
  endfunction

  function automatic logic [31:0] operand(input logic [31:0] raw);
    return half_mode ? half_to_single(raw[15:0]) : raw;
  endfunction

  // value = mag * 2^lsb_exp, rounded to nearest even with subnormals
  function automatic logic [31:0] round_single(input logic s, input int lsb_exp,
                                               input logic [63:0] mag);
    int          p;
    int          sh;
    int          lead;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] h;
    logic        up;
    if (mag == 64'd0) return {s, 31'd0};
    p = 63;
    while (!mag[p]) p--;
    sh = p - 23;
    if (sh < -149 - lsb_exp) sh = -149 - lsb_exp;
    if (sh > 64) return {s, 31'd0};
    if (sh <= 0) begin
      q = mag << (-sh);
    end else begin
      q = (sh == 64) ? 64'd0 : (mag >> sh);
      r = (sh == 64) ? mag : (mag - (q << sh));
      h = 64'd1 << (sh - 1);
      up = (r > h) || ((r == h) && q[0]);
      q = q + 64'(up);
    end
    if (q[24]) begin
      q = q >> 1;
      sh++;
    end
    lead = sh + lsb_exp + 150;
    if (!q[23]) return {s, 8'd0, q[22:0]};
    if (lead >= 255) return {s, 8'hFF, 23'd0};
    return {s, 8'(lead), q[22:0]};
  endfunction

  function automatic void split(input logic [31:0] b, output int ex, output logic [63:0] m);
    ex = ((b[30:23] == 8'd0) ? 1 : int'(b[30:23])) - 150;
    m = {40'd0, b[30:23] != 8'd0, b[22:0]};
  endfunction

  function automatic logic is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(input logic [31:0] b);
    return b[30:0] == 31'd0;
  endfunction

  function automatic logic [31:0] single_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    int          ea;
    int          eb;
    logic [63:0] ma;
    logic [63:0] mb;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return QNAN;
    if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) return QNAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
    split(a, ea, ma);
    split(b, eb, mb);
    return round_single(s, ea + eb, ma * mb);
  endfunction

  function automatic logic [31:0] single_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        t;
    int                 ea;
    int                 eb;
    int                 d;
    logic [63:0]        ma;
    logic [63:0]        mb;
    logic signed [66:0] total;
    if (is_nan(a) || is_nan(b)) return QNAN;
    if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
    split(a, ea, ma);
    split(b, eb, mb);
    if (ea < eb) begin
      t = a; a = b; b = t;
      split(a, ea, ma);
      split(b, eb, mb);
    end
    d = ea - eb;
    if (d > 38) begin
      ma = ma << 3;
      mb = 64'(mb != 64'd0);
      eb = ea - 3;
    end else begin
      ma = ma << d;
    end
    total = (a[31] ? -$signed({3'd0, ma}) : $signed({3'd0, ma}))
          + (b[31] ? -$signed({3'd0, mb}) : $signed({3'd0, mb}));
    if (total == 0) return 32'd0;
    if (total < 0) return round_single(1'b1, eb, 64'(-total));
    return round_single(1'b0, eb, 64'(total));
  endfunction

  task automatic predict_row(input logic [2:0] r);
    logic [31:0] acc;
    row_sum_t    e;
    for (int c = 0; c < COLS; c++) begin
      acc = 32'd0;
      for (int k = 0; k < INNER; k++)
        acc = single_add(acc, single_mul(operand(a_mirror[r * INNER + k]),
                                         operand(b_mirror[k * COLS + c])));
      if (is_nan(acc)) acc = QNAN;
      e.sum = acc;
      e.col = 4'(c);
      e.last = (c == COLS - 1);
      sums_due.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    row_sum_t e;
    if (rst) begin
      half_mode <= 1'b0;
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == ADDR_HALF_INPUTS[2])
        half_mode <= pwdata[0];
      if (start && !busy) begin
        case (op)
          OP_WR_A: if (element_index < A_DEPTH) a_mirror[element_index] = element_bits;
          OP_WR_B: b_mirror[element_index] = element_bits;
          OP_COMPUTE: predict_row(out_row);
          default: ;
        endcase
      end
      if (valid) begin
        if (sums_due.size() == 0) begin
          if (errors < 10) $display("unexpected result col %0d sum %h", out_column, sum_bits);
          errors <= errors + 1;
        end else begin
          e = sums_due[0];
          sums_due.delete(0);
          if (sum_bits !== e.sum || out_column !== e.col || last_of_row !== e.last) begin
            if (errors < 10)
              $display("mismatch: expected sum %h col %0d last %b, got sum %h col %0d last %b",
                       e.sum, e.col, e.last, sum_bits, out_column, last_of_row);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= sums_due.size();
  end

endmodule

[sim/matrix_tile_multiply_fp_tb.sv]
// testbench top of the matrix tile multiplier: stimulus, register writes and verdict
module matrix_tile_multiply_fp_tb;
  import mtm_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic [7:0]  element_index;
  logic [31:0] element_bits;
  logic [2:0]  out_row;
  logic        valid;
  logic [31:0] sum_bits;
  logic [3:0]  out_column;
  logic        last_of_row;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  logic        burst;

  matrix_tile_multiply_fp i_dut (.*);

  matrix_tile_multiply_fp_checker i_checker (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #(8 * 5000000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [31:0] pick_single();
    logic [31:0] specials [10] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                   32'h7FC0_0000, 32'h7F80_0001, 32'h0000_0001,
                                   32'h807F_FFFF, 32'h7F7F_FFFF, 32'h0080_0000};
    case ($urandom_range(0, 9))
      0: return specials[$urandom_range(0, 9)];
      1: return $urandom;
      default: return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] pick_half();
    logic [15:0] specials [8] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
                                  16'h0001, 16'h83FF, 16'h7BFF};
    logic [15:0] h;
    case ($urandom_range(0, 9))
      0: h = specials[$urandom_range(0, 7)];
      1: h = 16'($urandom);
      default: h = {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
    endcase
    return {16'($urandom), h};
  endfunction

  task automatic send(input logic [1:0] o, input logic [7:0] idx, input logic [31:0] bits,
                      input logic [2:0] r);
    int gap;
    if ($urandom_range(0, 19) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    element_index <= idx;
    element_bits <= bits;
    out_row <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_half_inputs(input logic v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_HALF_INPUTS;
    pwdata <= {31'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_items(input logic half, input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0, 1: send(OP_COMPUTE, 8'($urandom), $urandom, 3'($urandom));
        2: send(OP_NONE, 8'($urandom), $urandom, 3'($urandom));
        3: send(OP_WR_A, 8'($urandom_range(128, 255)), $urandom, 3'($urandom));
        4, 5, 6, 7, 8, 9, 10: send(OP_WR_A, 8'($urandom_range(0, 127)),
                                   half ? pick_half() : pick_single(), 3'($urandom));
        default: send(OP_WR_B, 8'($urandom), half ? pick_half() : pick_single(),
                      3'($urandom));
      endcase
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    int wait_cycles;
    burst = 1'b0;
    rst <= 1'b1;
    start <= 1'b0;
    op <= OP_WR_A;
    element_index <= 8'd0;
    element_bits <= 32'd0;
    out_row <= 3'd0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_HALF_INPUTS;
    pwdata <= 32'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < A_DEPTH; i++) send(OP_WR_A, 8'(i), pick_single(), 3'd0);
    for (int i = 0; i < B_DEPTH; i++) send(OP_WR_B, 8'(i), pick_single(), 3'd0);

    set_half_inputs(1'b0);
    send(OP_COMPUTE, 8'd0, 32'd0, 3'd7);
    send(OP_WR_A, 8'd0, 32'h7F80_0000, 3'd0);
    send(OP_WR_A, 8'd1, 32'h7FFF_FFFF, 3'd0);
    send(OP_WR_A, 8'd2, 32'h7F7F_FFFF, 3'd0);
    send(OP_WR_A, 8'd3, 32'h0000_0001, 3'd0);
    send(OP_WR_B, 8'd16, 32'h0000_0000, 3'd0);
    send(OP_WR_A, 8'd128, 32'hFFFF_FFFF, 3'd0);
    send(OP_WR_A, 8'd255, 32'hFFFF_FFFF, 3'd0);
    send(OP_NONE, 8'd0, 32'hFFFF_FFFF, 3'd7);
    send(OP_WR_B, 8'd255, 32'hFF7F_FFFF, 3'd0);
    send(OP_COMPUTE, 8'hFF, 32'hFFFF_FFFF, 3'd0);
    send(OP_COMPUTE, 8'd0, 32'd0, 3'd7);
    random_items(1'b0, 10);

    set_half_inputs(1'b1);
    send(OP_WR_A, 8'd16, 32'hFFFF_0001, 3'd0);
    send(OP_WR_A, 8'd17, 32'h0000_7C00, 3'd0);
    send(OP_WR_A, 8'd18, 32'h0000_03FF, 3'd0);
    send(OP_WR_A, 8'd19, 32'h0000_8000, 3'd0);
    send(OP_WR_A, 8'd20, 32'h0000_7E01, 3'd0);
    send(OP_WR_A, 8'd21, 32'h0000_7BFF, 3'd0);
    send(OP_COMPUTE, 8'd0, 32'd0, 3'd1);
    random_items(1'b1, 10);

    set_half_inputs(1'b0);
    random_items(1'b0, 10);
    set_half_inputs(1'b1);
    random_items(1'b1, 10);

    start <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/mtm_pkg.sv
hw/rtl/mtm_ram.sv
hw/rtl/mtm_ctrl.sv
hw/rtl/mtm_dp.sv
hw/rtl/matrix_tile_multiply_fp.sv
hw/rtl/mtm_checker.sv
sim/matrix_tile_multiply_fp_checker.sv
sim/matrix_tile_multiply_fp_tb.sv
